@@ design/dit_pkg.sv @@
// Package for the disjoint interval tracker.
// Holds the table sizes, the transaction and entry types and the
// sequencer/memory interface structs. No dependencies.
package dit_pkg;

   localparam int CAPACITY   = 32;
   localparam int VALUE_BITS = 16;
   localparam int IDX_W      = $clog2(CAPACITY);
   localparam int CNT_W      = $clog2(CAPACITY + 1);

   localparam logic MODE_ADD  = 1'b0;
   localparam logic MODE_READ = 1'b1;

   localparam logic KIND_ADD  = 1'b0;
   localparam logic KIND_READ = 1'b1;

   typedef struct packed {
      logic                  mode;
      logic [VALUE_BITS-1:0] value;
   } req_type;

   typedef struct packed {
      logic                  kind;
      logic [VALUE_BITS-1:0] range_start;
      logic [VALUE_BITS-1:0] range_end;
      logic                  last;
      logic                  empty_res;
      logic                  dropped;
      logic [CNT_W-1:0]      interval_count;
   } rsp_type;

   // One table row: closed interval [lo, hi].
   typedef struct packed {
      logic [VALUE_BITS-1:0] lo;
      logic [VALUE_BITS-1:0] hi;
   } entry_type;

   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] waddr;
      entry_type        wdata;
      logic [IDX_W-1:0] raddr;
   } mem_req_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } emit_type;

endpackage

@@ design/dit_ram.sv @@
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered; a read of the address being
// written returns the old contents. No dependencies.
module dit_ram #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 32,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/dit_seq.sv @@
// Sequencer for the interval table: walks the table through the RAM read
// port, updates rows in place and shifts rows up or down to insert or close.
// Depends on dit_pkg.
module dit_seq (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  dit_pkg::req_type    req_data,
   output dit_pkg::mem_req_type mem_req,
   input  dit_pkg::entry_type  mem_rdata,
   input  logic                out_free,
   output dit_pkg::emit_type   emit
);
   import dit_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_MERGE  = 3'd2;
   localparam logic [2:0] S_SHUP   = 3'd3;
   localparam logic [2:0] S_INS    = 3'd4;
   localparam logic [2:0] S_SHDN   = 3'd5;
   localparam logic [2:0] S_RDOUT  = 3'd6;
   localparam logic [2:0] S_RESULT = 3'd7;

   logic [2:0]            state_ff, state_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic [CNT_W-1:0]      ptr_ff, ptr_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic [VALUE_BITS-1:0] lo_ff, lo_in;
   logic [VALUE_BITS-1:0] hi_ff, hi_in;
   logic                  kind_ff, kind_in;
   logic                  empty_ff, empty_in;
   logic                  drop_ff, drop_in;

   logic [VALUE_BITS:0]   v_inc;
   logic [VALUE_BITS:0]   e_inc;
   logic [CNT_W-1:0]      idx_p1, idx_p2, ptr_p1, ptr_p2, ptr_m1, ptr_m2, cnt_m1;
   logic                  at_end, full, rd_last;

   assign v_inc   = {1'b0, val_ff} + (VALUE_BITS+1)'(1);
   assign e_inc   = {1'b0, mem_rdata.hi} + (VALUE_BITS+1)'(1);
   assign idx_p1  = idx_ff + CNT_W'(1);
   assign idx_p2  = idx_ff + CNT_W'(2);
   assign ptr_p1  = ptr_ff + CNT_W'(1);
   assign ptr_p2  = ptr_ff + CNT_W'(2);
   assign ptr_m1  = ptr_ff - CNT_W'(1);
   assign ptr_m2  = ptr_ff - CNT_W'(2);
   assign cnt_m1  = cnt_ff - CNT_W'(1);
   assign at_end  = (idx_ff == cnt_ff);
   assign full    = (cnt_ff == CNT_W'(CAPACITY));
   assign rd_last = (idx_p1 == cnt_ff);

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      ptr_in   = ptr_ff;
      cnt_in   = cnt_ff;
      val_in   = val_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      kind_in  = kind_ff;
      empty_in = empty_ff;
      drop_in  = drop_ff;

      mem_req.we       = 1'b0;
      mem_req.waddr    = idx_ff[IDX_W-1:0];
      mem_req.wdata.lo = val_ff;
      mem_req.wdata.hi = val_ff;
      mem_req.raddr    = '0;

      emit.valid                = 1'b0;
      emit.data.kind            = kind_ff;
      emit.data.range_start     = lo_ff;
      emit.data.range_end       = hi_ff;
      emit.data.last            = 1'b1;
      emit.data.empty_res       = empty_ff;
      emit.data.dropped         = drop_ff;
      emit.data.interval_count  = cnt_ff;

      unique case (state_ff)
         S_IDLE: begin
            mem_req.raddr = '0;
            if (req_valid) begin
               val_in   = req_data.value;
               idx_in   = '0;
               empty_in = 1'b0;
               drop_in  = 1'b0;
               if (req_data.mode == MODE_READ) begin
                  kind_in = KIND_READ;
                  if (cnt_ff == '0) begin
                     lo_in    = '0;
                     hi_in    = '0;
                     empty_in = 1'b1;
                     state_in = S_RESULT;
                  end else begin
                     state_in = S_RDOUT;
                  end
               end else begin
                  kind_in  = KIND_ADD;
                  state_in = S_SCAN;
               end
            end
         end

         // Row idx is on the read data; prefetch the next row.
         S_SCAN: begin
            mem_req.raddr = idx_p1[IDX_W-1:0];
            if (at_end) begin
               if (full) begin
                  drop_in = 1'b1;
                  lo_in   = '0;
                  hi_in   = '0;
               end else begin
                  mem_req.we = 1'b1;
                  cnt_in     = cnt_ff + CNT_W'(1);
                  lo_in      = val_ff;
                  hi_in      = val_ff;
               end
               state_in = S_RESULT;
            end else if (mem_rdata.lo > val_ff) begin
               if ({1'b0, mem_rdata.lo} == v_inc) begin
                  mem_req.we       = 1'b1;
                  mem_req.wdata.hi = mem_rdata.hi;
                  lo_in            = val_ff;
                  hi_in            = mem_rdata.hi;
                  state_in         = S_RESULT;
               end else if (full) begin
                  drop_in  = 1'b1;
                  lo_in    = '0;
                  hi_in    = '0;
                  state_in = S_RESULT;
               end else begin
                  // open a gap at idx: copy rows upward from the top
                  mem_req.raddr = cnt_m1[IDX_W-1:0];
                  ptr_in        = cnt_ff;
                  lo_in         = val_ff;
                  hi_in         = val_ff;
                  state_in      = S_SHUP;
               end
            end else if (mem_rdata.hi < val_ff) begin
               if (e_inc == {1'b0, val_ff}) begin
                  lo_in    = mem_rdata.lo;
                  state_in = S_MERGE;
               end else begin
                  idx_in = idx_p1;
               end
            end else begin
               lo_in    = mem_rdata.lo;
               hi_in    = mem_rdata.hi;
               state_in = S_RESULT;
            end
         end

         // Read data holds row idx+1; decide between join and extend.
         S_MERGE: begin
            mem_req.raddr = idx_p2[IDX_W-1:0];
            mem_req.we    = 1'b1;
            mem_req.wdata.lo = lo_ff;
            if ((idx_p1 < cnt_ff) && ({1'b0, mem_rdata.lo} == v_inc)) begin
               mem_req.wdata.hi = mem_rdata.hi;
               hi_in            = mem_rdata.hi;
               cnt_in           = cnt_m1;
               ptr_in           = idx_p1;
               state_in         = (idx_p2 < cnt_ff) ? S_SHDN : S_RESULT;
            end else begin
               mem_req.wdata.hi = val_ff;
               hi_in            = val_ff;
               state_in         = S_RESULT;
            end
         end

         // Close the gap: row ptr takes row ptr+1.
         S_SHDN: begin
            mem_req.raddr = ptr_p2[IDX_W-1:0];
            mem_req.we    = 1'b1;
            mem_req.waddr = ptr_ff[IDX_W-1:0];
            mem_req.wdata = mem_rdata;
            ptr_in        = ptr_p1;
            if (!(ptr_p1 < cnt_ff)) begin
               state_in = S_RESULT;
            end
         end

         // Open the gap: row ptr takes row ptr-1.
         S_SHUP: begin
            mem_req.raddr = ptr_m2[IDX_W-1:0];
            mem_req.we    = 1'b1;
            mem_req.waddr = ptr_ff[IDX_W-1:0];
            mem_req.wdata = mem_rdata;
            ptr_in        = ptr_m1;
            if (ptr_m1 == idx_ff) begin
               state_in = S_INS;
            end
         end

         S_INS: begin
            mem_req.we = 1'b1;
            cnt_in     = cnt_ff + CNT_W'(1);
            state_in   = S_RESULT;
         end

         // Row idx is on the read data; reread it while the output is full.
         S_RDOUT: begin
            mem_req.raddr = idx_ff[IDX_W-1:0];
            if (out_free) begin
               emit.valid            = 1'b1;
               emit.data.kind        = KIND_READ;
               emit.data.range_start = mem_rdata.lo;
               emit.data.range_end   = mem_rdata.hi;
               emit.data.last        = rd_last;
               emit.data.empty_res   = 1'b0;
               emit.data.dropped     = 1'b0;
               mem_req.raddr         = idx_p1[IDX_W-1:0];
               idx_in                = idx_p1;
               if (rd_last) begin
                  state_in = S_IDLE;
               end
            end
         end

         S_RESULT: begin
            if (out_free) begin
               emit.valid = 1'b1;
               state_in   = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      ptr_ff   <= ptr_in;
      val_ff   <= val_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      kind_ff  <= kind_in;
      empty_ff <= empty_in;
      drop_ff  <= drop_in;
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(CAPACITY))
      else $error("interval count above capacity");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !mem_req.we)
      else $error("table write while idle");

   a_emit_state: assert property (@(posedge clock) disable iff (reset)
      emit.valid |-> (out_free && (state_ff == S_RDOUT || state_ff == S_RESULT)))
      else $error("result emitted outside an output state");

   a_cnt_change: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && cnt_ff != $past(cnt_ff)) |->
         (state_ff == S_RESULT || state_ff == S_SHDN))
      else $error("interval count changed outside an update");

   a_read_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RDOUT) |-> (cnt_ff != '0 && idx_ff < cnt_ff))
      else $error("readout past the stored intervals");

endmodule

@@ design/disjoint_interval_tracker_core.sv @@
// Disjoint interval tracker: sorted table of closed intervals in one RAM.
// Add: the table is scanned row by row, then rows are moved for an insert or join;
//   each row is scanned at most once and moved at most once. The result waits for a free
//   output register; once it is registered, the next request can be accepted.
// Read: one result per stored interval per cycle while the output is not stalled.
// Reset clears the control and the interval count; table rows are not cleared.
module disjoint_interval_tracker_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  dit_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output dit_pkg::rsp_type rsp_data
);
   import dit_pkg::*;

   mem_req_type mem_req;
   entry_type   mem_rdata;
   emit_type    emit;
   logic        out_free;

   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   dit_ram #(
      .DEPTH (CAPACITY),
      .WIDTH ($bits(entry_type))
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_req.we),
      .wr_addr (mem_req.waddr),
      .wr_data (mem_req.wdata),
      .rd_addr (mem_req.raddr),
      .rd_data (mem_rdata)
   );

   dit_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .mem_req   (mem_req),
      .mem_rdata (mem_rdata),
      .out_free  (out_free),
      .emit      (emit)
   );

   // Output register frees up when empty or when taken this cycle.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (emit.valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = emit.data;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
